FILE: rtl/core/date_string_validator_macros.svh
// Assertion macros for the date string validator.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef DATE_STRING_VALIDATOR_MACROS_SVH
`define DATE_STRING_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date_string_validator: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("date_string_validator: next-cycle check failed");

`endif

FILE: rtl/core/dsv_pkg.sv
// Shared types and constants for the date string validator.
// No dependencies; compiled first.
package dsv_pkg;

  localparam int CH_W    = 8;
  localparam int DAY_W   = 7;
  localparam int MONTH_W = 7;
  localparam int YEAR_W  = 14;
  localparam int LEN_W   = 3;
  localparam int BCD_W   = 4;

  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  localparam int DEC_BASE = 10;

  localparam logic [LEN_W-1:0] DM_LEN_MAX   = 3'd2;
  localparam logic [LEN_W-1:0] YEAR_LEN_MAX = 3'd4;
  localparam logic [LEN_W-1:0] YEAR_LEN_MIN = 3'd2;
  localparam logic [LEN_W-1:0] LEN_SAT      = 3'd7;

  localparam logic [DAY_W-1:0]   DAY_MIN     = 7'd1;
  localparam logic [DAY_W-1:0]   DAY_MAX     = 7'd31;
  localparam logic [DAY_W-1:0]   DAY_MAX_30  = 7'd30;
  localparam logic [DAY_W-1:0]   DAY_FEB_MAX = 7'd29;
  localparam logic [MONTH_W-1:0] MONTH_MIN   = 7'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAX   = 7'd12;
  localparam logic [MONTH_W-1:0] MON_FEB     = 7'd2;
  localparam logic [MONTH_W-1:0] MON_APR     = 7'd4;
  localparam logic [MONTH_W-1:0] MON_JUN     = 7'd6;
  localparam logic [MONTH_W-1:0] MON_SEP     = 7'd9;
  localparam logic [MONTH_W-1:0] MON_NOV     = 7'd11;

  typedef enum logic [1:0] {
    PH_DAY   = 2'd0,
    PH_MONTH = 2'd1,
    PH_YEAR  = 2'd2
  } phase_t;

  // Running parse state; the year is also kept as four BCD digits for the leap test.
  typedef struct packed {
    phase_t               phase;
    logic [LEN_W-1:0]     len;
    logic                 fmt_bad;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
    logic [BCD_W-1:0]     y_thou;
    logic [BCD_W-1:0]     y_hund;
    logic [BCD_W-1:0]     y_tens;
    logic [BCD_W-1:0]     y_units;
  } fields_t;

  localparam fields_t FIELDS_RST = '{
    phase:   PH_DAY,
    len:     '0,
    fmt_bad: 1'b0,
    day:     '0,
    month:   '0,
    year:    '0,
    y_thou:  '0,
    y_hund:  '0,
    y_tens:  '0,
    y_units: '0
  };

  typedef struct packed {
    logic                 valid_res;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
  } result_t;

endpackage

FILE: rtl/core/dsv_if.sv
// Valid/ready channel interfaces for the date string validator.
// Depends on dsv_pkg for payload widths.
interface dsv_in_if import dsv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface dsv_out_if import dsv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;

  modport source (output valid, valid_res, day, month, year, input ready);
  modport sink   (input valid, valid_res, day, month, year, output ready);
endinterface

FILE: rtl/core/date_string_validator.sv
// Top level of the date string validator: input register, parser, checker, result register.
// Depends on dsv_pkg, dsv_if, dsv_field_parser, dsv_date_check and the macros header.
//
// Takes a dd/mm/yyyy date string one character per beat, with last set on the
// final character, and returns one result beat per string: valid_res plus day,
// month and year (zeros when the date is rejected). The block accepts one
// character every clock; the parser's field update is the only
// loop, so throughput is one character per cycle with no gaps between strings.
// A final character passes through the input register and its result through the
// result register. Characters keep flowing while a result waits; only a second final
// character stalls behind an untaken result.
`include "date_string_validator_macros.svh"

module date_string_validator import dsv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dsv_in_if.sink    in_bus,
  dsv_out_if.source out_bus
);

  logic            s1_v_r;
  logic [CH_W-1:0] s1_ch_r;
  logic            s1_last_r;
  logic            out_v_r;
  result_t         res_r;
  result_t         chk_res;
  fields_t         fld;
  logic            out_free;
  logic            s1_go;
  logic            in_fire;

  assign out_free     = !out_v_r || out_bus.ready;
  assign s1_go        = s1_v_r && (!s1_last_r || out_free);
  assign in_bus.ready = !s1_v_r || s1_go;
  assign in_fire      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r   <= in_bus.ch;
      s1_last_r <= in_bus.last;
    end
  end

  dsv_field_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_go),
    .ch    (s1_ch_r),
    .last  (s1_last_r),
    .fld   (fld)
  );

  dsv_date_check u_check (
    .fld (fld),
    .res (chk_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      res_r <= chk_res;
    end
  end

  assign out_bus.valid     = out_v_r;
  assign out_bus.valid_res = res_r.valid_res;
  assign out_bus.day       = res_r.day;
  assign out_bus.month     = res_r.month;
  assign out_bus.year      = res_r.year;

  `DSV_ASSERT_IMP(a_empty_ready, clk, rst_n, !s1_v_r, in_bus.ready)
  `DSV_ASSERT_NXT(a_final_lands, clk, rst_n, s1_go && s1_last_r, out_v_r)
  `DSV_ASSERT_IMP(a_valid_ranges, clk, rst_n, out_v_r && res_r.valid_res,
    (res_r.day >= DAY_MIN) && (res_r.day <= DAY_MAX) &&
    (res_r.month >= MONTH_MIN) && (res_r.month <= MONTH_MAX))
  `DSV_ASSERT_IMP(a_reject_zero, clk, rst_n, out_v_r && !res_r.valid_res,
    (res_r.day == '0) && (res_r.month == '0) && (res_r.year == '0))

endmodule

FILE: rtl/core/dsv_field_parser.sv
// Per-character field parser: holds the running day/month/year state.
// Depends on dsv_pkg. Presents the post-update fields to the date checker.
module dsv_field_parser import dsv_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic [CH_W-1:0] ch,
  input  logic            last,
  output fields_t         fld
);

  fields_t          st_r;
  fields_t          st_nxt;
  logic             stop_r;
  logic             stop_nxt;
  phase_t           phase_nxt;
  logic             in_year;
  logic             is_slash;
  logic             is_digit;
  logic             take;
  logic [BCD_W-1:0] dig;
  logic [LEN_W-1:0] maxlen;

  always_comb begin
    in_year  = (st_r.phase != PH_DAY) && (st_r.phase != PH_MONTH);
    is_slash = (ch == CH_SLASH);
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dig      = ch[BCD_W-1:0];
    maxlen   = in_year ? YEAR_LEN_MAX : DM_LEN_MAX;
    take     = is_digit && !stop_r && (st_r.len < maxlen);
  end

  // field sequencing: a slash moves on only outside the year field
  always_comb begin
    phase_nxt = st_r.phase;
    if (is_slash && !in_year) begin
      unique case (st_r.phase)
        PH_DAY:   phase_nxt = PH_MONTH;
        PH_MONTH: phase_nxt = PH_YEAR;
        default:  phase_nxt = st_r.phase;
      endcase
    end
  end

  always_comb begin
    st_nxt       = st_r;
    st_nxt.phase = phase_nxt;
    stop_nxt     = stop_r;
    if (is_slash && !in_year) begin
      if ((st_r.len == '0) || (st_r.len > DM_LEN_MAX)) begin
        st_nxt.fmt_bad = 1'b1;
      end
      st_nxt.len = '0;
      stop_nxt   = 1'b0;
    end else begin
      if (!is_digit) begin
        stop_nxt = 1'b1;
      end
      if (take) begin
        unique case (st_r.phase)
          PH_DAY: begin
            st_nxt.day = st_r.day * DAY_W'(DEC_BASE) + DAY_W'(dig);
          end
          PH_MONTH: begin
            st_nxt.month = st_r.month * MONTH_W'(DEC_BASE) + MONTH_W'(dig);
          end
          default: begin
            st_nxt.year    = st_r.year * YEAR_W'(DEC_BASE) + YEAR_W'(dig);
            st_nxt.y_thou  = st_r.y_hund;
            st_nxt.y_hund  = st_r.y_tens;
            st_nxt.y_tens  = st_r.y_units;
            st_nxt.y_units = dig;
          end
        endcase
      end
      if (st_r.len != LEN_SAT) begin
        st_nxt.len = st_r.len + 1'b1;
      end
    end
  end

  assign fld = st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= FIELDS_RST;
      stop_r <= 1'b0;
    end else if (adv) begin
      if (last) begin
        st_r   <= FIELDS_RST;
        stop_r <= 1'b0;
      end else begin
        st_r   <= st_nxt;
        stop_r <= stop_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/dsv_date_check.sv
// Calendar check on the parsed fields: format, ranges, 30-day months, February and leap years.
// Depends on dsv_pkg. Pure combinational; the top level registers its result.
module dsv_date_check import dsv_pkg::*; (
  input  fields_t fld,
  output result_t res
);

  logic       fmt_ok;
  logic       range_ok;
  logic       thirty;
  logic       feb;
  logic       lo_zero;
  logic [1:0] lo_mod4;
  logic [1:0] hi_mod4;
  logic       leap;
  logic       ok;

  always_comb begin
    fmt_ok = !fld.fmt_bad && (fld.phase != PH_DAY) && (fld.phase != PH_MONTH) &&
             ((fld.len == YEAR_LEN_MIN) || (fld.len == YEAR_LEN_MAX));
    range_ok = (fld.day >= DAY_MIN) && (fld.day <= DAY_MAX) &&
               (fld.month >= MONTH_MIN) && (fld.month <= MONTH_MAX);
    thirty = (fld.month == MON_APR) || (fld.month == MON_JUN) ||
             (fld.month == MON_SEP) || (fld.month == MON_NOV);
    feb    = (fld.month == MON_FEB);

    // y mod 4 from the last two digits: (2*tens + units) mod 4; the 2000 offset
    // for two-digit years is a multiple of 400 and leaves the test unchanged
    lo_zero = (fld.y_tens == '0) && (fld.y_units == '0);
    lo_mod4 = {fld.y_tens[0], 1'b0} + fld.y_units[1:0];
    hi_mod4 = {fld.y_thou[0], 1'b0} + fld.y_hund[1:0];
    leap    = lo_zero ? (hi_mod4 == 2'd0) : (lo_mod4 == 2'd0);

    ok = fmt_ok && range_ok && !(thirty && (fld.day > DAY_MAX_30));
    if (feb) begin
      if (fld.day > DAY_FEB_MAX) begin
        ok = 1'b0;
      end else if ((fld.day == DAY_FEB_MAX) && !leap) begin
        ok = 1'b0;
      end
    end

    res.valid_res = ok;
    res.day       = ok ? fld.day   : '0;
    res.month     = ok ? fld.month : '0;
    res.year      = ok ? fld.year  : '0;
  end

endmodule

FILE: tb/date_string_validator_test.sv
// Self-checking testbench for date_string_validator: streams date strings one character
// per beat, predicts each string's verdict and compares it with the result channel.
// Depends on dsv_pkg, dsv_if and the date_string_validator RTL.
module date_string_validator_test import dsv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAR_TARGET = 1650;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;

  // Running parse of the current string; one verdict is queued per final character.
  class date_verdict_board;
    phase_t            phase;
    int                flen;
    bit                stopped;
    bit                fmt_bad;
    int                day_acc;
    int                month_acc;
    int                year_acc;
    result_t           verdicts[$];
    int                errors;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase     = PH_DAY;
      flen      = 0;
      stopped   = 0;
      fmt_bad   = 0;
      day_acc   = 0;
      month_acc = 0;
      year_acc  = 0;
    endfunction

    function bit leap_year(int y);
      if (y >= 10 && y <= 99)
        y += 2000;
      if (y % 400 == 0)
        return 1;
      return (y % 4 == 0) && (y % 100 != 0);
    endfunction

    function void take_char(bit [7:0] c, bit fin);
      bit      in_year;
      int      maxlen;
      int      dig;
      bit      ok;
      result_t r;
      in_year = (phase >= PH_YEAR);
      if (c == CH_SLASH && !in_year) begin
        if (flen < 1 || flen > DM_LEN_MAX)
          fmt_bad = 1;
        phase   = (phase == PH_DAY) ? PH_MONTH : PH_YEAR;
        flen    = 0;
        stopped = 0;
      end else begin
        maxlen = in_year ? YEAR_LEN_MAX : DM_LEN_MAX;
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (!stopped && flen < maxlen) begin
            dig = c - CH_ZERO;
            case (phase)
              PH_DAY:   day_acc = day_acc * DEC_BASE + dig;
              PH_MONTH: month_acc = month_acc * DEC_BASE + dig;
              default:  year_acc = year_acc * DEC_BASE + dig;
            endcase
          end
        end else begin
          stopped = 1;
        end
        if (flen < LEN_SAT)
          flen++;
      end
      if (!fin)
        return;

      ok = 1;
      if (fmt_bad || phase < PH_YEAR)
        ok = 0;
      if (flen != YEAR_LEN_MIN && flen != YEAR_LEN_MAX)
        ok = 0;
      if (day_acc < DAY_MIN || day_acc > DAY_MAX)
        ok = 0;
      if (month_acc < MONTH_MIN || month_acc > MONTH_MAX)
        ok = 0;
      if ((month_acc == MON_APR || month_acc == MON_JUN || month_acc == MON_SEP ||
           month_acc == MON_NOV) && day_acc > DAY_MAX_30)
        ok = 0;
      if (month_acc == MON_FEB) begin
        if (day_acc > DAY_FEB_MAX)
          ok = 0;
        else if (day_acc == DAY_FEB_MAX && !leap_year(year_acc))
          ok = 0;
      end
      r.valid_res = ok;
      r.day       = ok ? day_acc[DAY_W-1:0] : '0;
      r.month     = ok ? month_acc[MONTH_W-1:0] : '0;
      r.year      = ok ? year_acc[YEAR_W-1:0] : '0;
      verdicts.push_back(r);
      clear_parse();
    endfunction

    function void match_result(logic vr, logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                               logic [YEAR_W-1:0] y);
      result_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: result beat with nothing pending: valid_res %0d day %0d month %0d year %0d",
                 $time, vr, d, m, y);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (vr !== want.valid_res) begin
        $display("%0t: valid_res expected %0d actual %0d", $time, want.valid_res, vr);
        errors++;
      end
      if (d !== want.day) begin
        $display("%0t: day expected %0d actual %0d", $time, want.day, d);
        errors++;
      end
      if (m !== want.month) begin
        $display("%0t: month expected %0d actual %0d", $time, want.month, m);
        errors++;
      end
      if (y !== want.year) begin
        $display("%0t: year expected %0d actual %0d", $time, want.year, y);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dsv_in_if  in_bus ();
  dsv_out_if out_bus ();

  date_string_validator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  date_verdict_board verdict_board = new();

  bit [7:0] str_q[$];
  int       burst_left   = 0;
  int       chars_sent   = 0;
  int       results_seen = 0;
  int       idle_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.ch     <= '0;
    in_bus.last   <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Result side: stretches of steady, random and periodic back-pressure,
  // plus one long hold once traffic is flowing.
  initial begin : result_sink
    int mode;
    int stretch;
    int tick;
    int hold_left;
    bit held;
    mode      = 0;
    stretch   = 0;
    tick      = 0;
    hold_left = 0;
    held      = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 40) begin
        held      = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(10, 80);
          tick    = 0;
        end
        stretch--;
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom_range(0, 1));
          default: out_bus.ready <= (tick % 5) < 3;
        endcase
        tick++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      verdict_board.match_result(out_bus.valid_res, out_bus.day, out_bus.month, out_bus.year);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_char(bit [7:0] c, bit fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid <= 1'b1;
    in_bus.ch    <= c;
    in_bus.last  <= fin;
    do @(posedge clk); while (!in_bus.ready);
    verdict_board.take_char(c, fin);
    chars_sent++;
  endtask

  task automatic send_string();
    foreach (str_q[i])
      send_char(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endtask

  // Sender goes quiet until every pending verdict has come back.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (verdict_board.pending() != 0);
    burst_left = 0;
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++)
      str_q.push_back(s[i]);
  endfunction

  function automatic void put_num(int v, int ndig);
    for (int i = ndig - 1; i >= 0; i--)
      str_q.push_back(8'(CH_ZERO + (v / (10 ** i)) % 10));
  endfunction

  function automatic int pick_year4();
    int specials[8] = '{0, 1600, 1900, 2000, 2024, 2100, 2400, 9999};
    if ($urandom_range(0, 9) < 3)
      return specials[$urandom_range(0, 7)];
    return $urandom_range(0, 9999);
  endfunction

  function automatic void make_date();
    int r;
    int d;
    int m;
    r = $urandom_range(0, 9);
    if (r < 3)
      d = $urandom_range(28, 31);
    else if (r < 4)
      d = $urandom_range(0, 99);
    else
      d = $urandom_range(1, 31);
    r = $urandom_range(0, 9);
    if (r < 3)
      m = MON_FEB;
    else if (r < 4)
      m = $urandom_range(0, 99);
    else
      m = $urandom_range(1, 12);
    put_num(d, (d < 10 && $urandom_range(0, 1)) ? 1 : 2);
    str_q.push_back(CH_SLASH);
    put_num(m, (m < 10 && $urandom_range(0, 1)) ? 1 : 2);
    str_q.push_back(CH_SLASH);
    if ($urandom_range(0, 1))
      put_num($urandom_range(0, 99), 2);
    else
      put_num(pick_year4(), 4);
  endfunction

  // Break a well-formed date: stray byte, inserted sign/space/slash/NUL/digit, dropped char.
  function automatic void mangle_date();
    int pos;
    bit [7:0] picks[7];
    picks = '{8'h20, 8'h2B, 8'h2D, CH_SLASH, 8'h00, CH_ZERO, CH_NINE};
    pos = $urandom_range(0, str_q.size() - 1);
    case ($urandom_range(0, 3))
      0: str_q[pos] = 8'($urandom_range(0, 255));
      1: str_q.insert(pos, picks[$urandom_range(0, 6)]);
      2: if (str_q.size() > 1) str_q.delete(pos);
      default: str_q.insert(pos, 8'(CH_ZERO + $urandom_range(0, 9)));
    endcase
  endfunction

  function automatic void make_noise();
    int len;
    int r;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r < 4)
        str_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      else if (r < 6)
        str_q.push_back(CH_SLASH);
      else
        str_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin : stimulus
    int next_drain;
    int kind;
    next_drain = 450;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // leap day in year zero, April 31st, lone 0xFF and NUL, largest month and year
    put_text("29/2/00");
    send_string();
    put_text("31/4/24");
    send_string();
    str_q.push_back(8'hFF);
    send_string();
    str_q.push_back(8'h00);
    send_string();
    put_text("1/12/9999");
    send_string();

    while (chars_sent < CHAR_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        make_date();
      end else if (kind < 88) begin
        make_date();
        mangle_date();
      end else begin
        make_noise();
      end
      send_string();
      if (chars_sent >= next_drain) begin
        drain_results();
        next_drain += 450;
      end
    end

    in_bus.valid <= 1'b0;
    while (verdict_board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (verdict_board.errors == 0 && verdict_board.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
